// ----- src/soms_pkg.sv -----
// Package for the spiral-order matrix scan.
// Holds the walk direction and sequencer types, the store read request struct
// and the fixed store and register-index constants. Depends on nothing.
package soms_pkg;

	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = 6;
	localparam int DATA_W      = 32;
	localparam int SIZE_W      = 4;
	localparam int POS_W       = 3;
	localparam int COUNT_W     = 7;

	// configuration register indexes
	localparam logic REG_ROW_COUNT    = 1'b0;
	localparam logic REG_COLUMN_COUNT = 1'b1;

	typedef enum logic [1:0] {
		DIR_RIGHT = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_UP    = 2'd3
	} dir_t;

	typedef enum logic {
		WS_IDLE = 1'b0,
		WS_RUN  = 1'b1
	} walk_state_t;

	// read request from the walker to the element store
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic              last;
	} rd_req_t;

endpackage

// ----- src/soms_store.sv -----
// Element store: 64 x 32 single write port, one registered read port.
// Depends on soms_pkg for widths.
module soms_store (
	input  logic                          clk,
	input  logic                          we,
	input  logic [soms_pkg::ADDR_W-1:0]   waddr,
	input  logic [soms_pkg::DATA_W-1:0]   wdata,
	input  logic                          re,
	input  logic [soms_pkg::ADDR_W-1:0]   raddr,
	output logic [soms_pkg::DATA_W-1:0]   rdata
);

	logic [soms_pkg::DATA_W-1:0] mem_q [soms_pkg::STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/soms_walker.sv -----
// Spiral walker: steps row/column position and bounds one cell per cycle and
// keeps the store address with a single shared adder. Depends on soms_pkg.
module soms_walker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             go,
	input  logic [soms_pkg::SIZE_W-1:0]      rows,
	input  logic [soms_pkg::SIZE_W-1:0]      cols,
	input  logic [soms_pkg::COUNT_W-1:0]     total,
	output soms_pkg::rd_req_t                rd,
	output logic                             running
);

	soms_pkg::walk_state_t state_q, state_d;
	soms_pkg::dir_t        dir_q, dir_d;

	logic [soms_pkg::POS_W-1:0]   row_q, row_d, col_q, col_d;
	logic [soms_pkg::POS_W-1:0]   top_q, top_d, bottom_q, bottom_d;
	logic [soms_pkg::POS_W-1:0]   left_q, left_d, right_q, right_d;
	logic [soms_pkg::ADDR_W-1:0]  addr_q, addr_d;
	logic [soms_pkg::COUNT_W-1:0] remain_q, remain_d;
	logic [soms_pkg::SIZE_W-1:0]  cols_q, cols_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= soms_pkg::WS_IDLE;
			dir_q   <= soms_pkg::DIR_RIGHT;
		end else begin
			state_q <= state_d;
			dir_q   <= dir_d;
		end
	end

	always_ff @(posedge clk) begin
		row_q    <= row_d;
		col_q    <= col_d;
		top_q    <= top_d;
		bottom_q <= bottom_d;
		left_q   <= left_d;
		right_q  <= right_d;
		addr_q   <= addr_d;
		remain_q <= remain_d;
		cols_q   <= cols_d;
	end

	always_comb begin
		logic [soms_pkg::ADDR_W-1:0] delta;
		logic [soms_pkg::ADDR_W-1:0] col_step;
		state_d  = state_q;
		dir_d    = dir_q;
		row_d    = row_q;
		col_d    = col_q;
		top_d    = top_q;
		bottom_d = bottom_q;
		left_d   = left_q;
		right_d  = right_q;
		addr_d   = addr_q;
		remain_d = remain_q;
		cols_d   = cols_q;
		rd       = '0;
		col_step = soms_pkg::ADDR_W'(cols_q);
		delta    = '0;
		case (state_q)
			soms_pkg::WS_IDLE: begin
				if (go) begin
					state_d  = soms_pkg::WS_RUN;
					dir_d    = soms_pkg::DIR_RIGHT;
					row_d    = '0;
					col_d    = '0;
					top_d    = '0;
					left_d   = '0;
					bottom_d = soms_pkg::POS_W'(rows - soms_pkg::SIZE_W'(1));
					right_d  = soms_pkg::POS_W'(cols - soms_pkg::SIZE_W'(1));
					addr_d   = '0;
					remain_d = total - soms_pkg::COUNT_W'(1);
					cols_d   = cols;
				end
			end
			soms_pkg::WS_RUN: begin
				rd.en   = 1'b1;
				rd.addr = addr_q;
				rd.last = (remain_q == '0);
				if (rd.last) begin
					state_d = soms_pkg::WS_IDLE;
				end else begin
					remain_d = remain_q - soms_pkg::COUNT_W'(1);
					// at the end of a pass: shrink that bound and turn clockwise
					case (dir_q)
						soms_pkg::DIR_RIGHT: begin
							if (col_q != right_q) begin
								col_d = col_q + soms_pkg::POS_W'(1);
							end else begin
								top_d = top_q + soms_pkg::POS_W'(1);
								row_d = row_q + soms_pkg::POS_W'(1);
								dir_d = soms_pkg::DIR_DOWN;
							end
						end
						soms_pkg::DIR_DOWN: begin
							if (row_q != bottom_q) begin
								row_d = row_q + soms_pkg::POS_W'(1);
							end else begin
								right_d = right_q - soms_pkg::POS_W'(1);
								col_d   = col_q - soms_pkg::POS_W'(1);
								dir_d   = soms_pkg::DIR_LEFT;
							end
						end
						soms_pkg::DIR_LEFT: begin
							if (col_q != left_q) begin
								col_d = col_q - soms_pkg::POS_W'(1);
							end else begin
								bottom_d = bottom_q - soms_pkg::POS_W'(1);
								row_d    = row_q - soms_pkg::POS_W'(1);
								dir_d    = soms_pkg::DIR_UP;
							end
						end
						default: begin
							if (row_q != top_q) begin
								row_d = row_q - soms_pkg::POS_W'(1);
							end else begin
								left_d = left_q + soms_pkg::POS_W'(1);
								col_d  = col_q + soms_pkg::POS_W'(1);
								dir_d  = soms_pkg::DIR_RIGHT;
							end
						end
					endcase
					// address moves with the direction of the next cell
					case (dir_d)
						soms_pkg::DIR_RIGHT: delta = soms_pkg::ADDR_W'(1);
						soms_pkg::DIR_DOWN:  delta = col_step;
						soms_pkg::DIR_LEFT:  delta = '1;
						default:             delta = ~col_step + soms_pkg::ADDR_W'(1);
					endcase
					addr_d = addr_q + delta;
				end
			end
			default: begin
				state_d = soms_pkg::WS_IDLE;
			end
		endcase
	end

	assign running = (state_q == soms_pkg::WS_RUN);

endmodule

// ----- src/spiral_order_matrix_scan.sv -----
// Top level of the spiral-order matrix scan: config registers, load counter,
// element store and spiral walker. Depends on soms_pkg, soms_store, soms_walker.
//
//  channel  | ports                               | handshake
//  ---------+-------------------------------------+--------------------------------
//  element  | start, busy, element_value          | transfer when start && !busy
//  result   | result_valid, spiral_value, final_flag | one-cycle strobe, no backpressure
//  config   | cfg_we, cfg_index, cfg_data         | write when cfg_we
//
// Each accepted transfer loads one element. The element that completes the matrix
// starts the walk: busy rises, and rows*cols results follow one per cycle, each read
// registered in the store; one read port and the address adder set that pace. busy
// falls after the walker issues its last read. Reset clears the load counter, walker
// state and output flags, sets both counts to 8; the store needs no clearing pass.
module spiral_order_matrix_scan #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [soms_pkg::DATA_W-1:0] element_value,
	output logic                               result_valid,
	output logic signed [soms_pkg::DATA_W-1:0] spiral_value,
	output logic                               final_flag,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [soms_pkg::SIZE_W-1:0]        cfg_data
);

	logic [soms_pkg::SIZE_W-1:0]  row_count_q, column_count_q;
	logic [soms_pkg::SIZE_W-1:0]  rows_c, cols_c;
	logic [soms_pkg::COUNT_W-1:0] total;
	logic [soms_pkg::COUNT_W-1:0] load_cnt_q, load_cnt_inc;
	logic                         accept, go;
	logic                         running;
	logic                         valid_s1, last_s1;
	logic [soms_pkg::DATA_W-1:0]  rdata;
	soms_pkg::rd_req_t            rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= soms_pkg::SIZE_W'(8);
			column_count_q <= soms_pkg::SIZE_W'(8);
		end else if (cfg_we) begin
			case (cfg_index)
				soms_pkg::REG_ROW_COUNT:    row_count_q    <= cfg_data;
				soms_pkg::REG_COLUMN_COUNT: column_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero reads as one, anything above the maximum reads as the maximum
	always_comb begin
		if (row_count_q == '0) begin
			rows_c = soms_pkg::SIZE_W'(1);
		end else if (row_count_q > soms_pkg::SIZE_W'(MAX_ROWS)) begin
			rows_c = soms_pkg::SIZE_W'(MAX_ROWS);
		end else begin
			rows_c = row_count_q;
		end
		if (column_count_q == '0) begin
			cols_c = soms_pkg::SIZE_W'(1);
		end else if (column_count_q > soms_pkg::SIZE_W'(MAX_COLS)) begin
			cols_c = soms_pkg::SIZE_W'(MAX_COLS);
		end else begin
			cols_c = column_count_q;
		end
	end

	assign total        = soms_pkg::COUNT_W'(rows_c) * soms_pkg::COUNT_W'(cols_c);
	assign busy         = running;
	assign accept       = start && !busy;
	assign load_cnt_inc = load_cnt_q + soms_pkg::COUNT_W'(1);
	// a shrunk size mid-load also lands here, so the walk starts at once
	assign go           = accept && (load_cnt_inc >= total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
		end else if (accept) begin
			load_cnt_q <= go ? '0 : load_cnt_inc;
		end
	end

	soms_store u_store (
		.clk   (clk),
		.we    (accept),
		.waddr (load_cnt_q[soms_pkg::ADDR_W-1:0]),
		.wdata (element_value),
		.re    (rd.en),
		.raddr (rd.addr),
		.rdata (rdata)
	);

	soms_walker u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.rows    (rows_c),
		.cols    (cols_c),
		.total   (total),
		.rd      (rd),
		.running (running)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= rd.en;
			last_s1  <= rd.en && rd.last;
		end
	end

	assign result_valid = valid_s1;
	assign final_flag   = last_s1;
	assign spiral_value = rdata;

endmodule
